// ----- rtl/hpt_pkg.sv -----
// Shared types and constants of the hall pulse tachometer.
// Used by the output channel interface, the top level and its checker.
package hpt_pkg;

	localparam int FREQ_W  = 32;
	localparam int SPEED_W = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	localparam int MAG_W = 8;
	localparam int RAD_W = 12;
	localparam int DEB_W = 16;
	localparam int TMO_W = 32;

	// 1e6 scaled to Q16.16, the dividend of the frequency.
	localparam logic [35:0] FREQ_NUM_Q16 = 36'd65536000000;
	// Two pi in unsigned Q16.16.
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGNETS  = 3'd0,
		REG_RADIUS   = 3'd1,
		REG_DEBOUNCE = 3'd2,
		REG_TIMEOUT  = 3'd3
	} cfg_reg_t;

endpackage

// ----- rtl/hpt_if.sv -----
// Valid/ready channels of the hall pulse tachometer: ticks in, reports out.
// Depends on hpt_pkg for the field widths.
interface hpt_in_if;
	logic valid;
	logic ready;
	logic edge_seen;

	modport source (output valid, output edge_seen, input ready);
	modport sink (input valid, input edge_seen, output ready);
endinterface

interface hpt_out_if import hpt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [FREQ_W-1:0]    frequency_q16;
	logic [SPEED_W-1:0]   speed_q8;
	logic                 timed_out;

	modport source (output valid, output frequency_q16, output speed_q8, output timed_out,
		input ready);
	modport sink (input valid, input frequency_q16, input speed_q8, input timed_out,
		output ready);
endinterface

// ----- rtl/hall_pulse_tachometer.sv -----
// Hall pulse tachometer: one item per microsecond tick, a report per period or timeout.
// A tick that measures nothing is taken in S_IDLE alone. A measuring edge is accepted
// in S_IDLE, then S_DEN forms the divisor, S_LOAD loads the dividend, S_DIV runs one
// restoring divider step per quotient bit (41 bits at TICK_WIDTH 32), S_SPD1 and S_SPD2
// form the speed products and S_OUT loads the report. Ready stays low meanwhile and
// while a report waits at the output and is not taken. Reset (arst_n low) drops the reference,
// clears the counters and loads register defaults. Uses hpt_pkg and the hpt_if.sv channels.
module hall_pulse_tachometer import hpt_pkg::*; #(
	parameter int TICK_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	hpt_in_if.sink               tick,
	hpt_out_if.source            result
);

	localparam int DW  = TICK_WIDTH + MAG_W;
	localparam int NW  = ((DW > 36) ? DW : 36) + 1;
	localparam int CW  = $clog2(NW + 1);
	localparam int T1W = FREQ_W + 19;
	localparam int T2W = T1W + RAD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEN,
		S_LOAD,
		S_DIV,
		S_SPD1,
		S_SPD2,
		S_OUT
	} state_t;

	state_t state_q;

	logic [MAG_W-1:0] magnets_q;
	logic [RAD_W-1:0] radius_q;
	logic [DEB_W-1:0] debounce_q;
	logic [TMO_W-1:0] timeout_q;

	logic [TICK_WIDTH-1:0] since_edge_q;
	logic [31:0]           since_report_q;
	logic                  have_ref_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;

	logic [TICK_WIDTH-1:0] period_q;
	logic [DW-1:0]         den_q;
	logic [NW-1:0]         num_q;
	logic [DW-1:0]         rem_q;
	logic [FREQ_W-1:0]     freq_q;
	logic [T1W-1:0]        t1_q;
	logic [T2W-1:0]        t2_q;
	logic [FREQ_W-1:0]     out_freq_q;
	logic [SPEED_W-1:0]    out_speed_q;
	logic                  out_tmo_q;

	logic                  accept;
	logic [TICK_WIDTH-1:0] elapsed;
	logic [31:0]           silent;
	logic                  edge_ok;
	logic                  tmo_hit;
	logic                  tmo_rep;
	logic                  rep_load;
	logic [MAG_W-1:0]      mag_eff;
	logic [DW:0]           rem_sh;
	logic                  rem_ge;
	logic [63:0]           spd_round;
	logic [FREQ_W-1:0]     freq_sat;
	logic [SPEED_W-1:0]    speed_sat;

	assign tick.ready = (state_q == S_IDLE) && (!out_valid_q || result.ready);
	assign accept     = tick.valid && tick.ready;

	assign elapsed = (&since_edge_q) ? since_edge_q : since_edge_q + 1'b1;
	assign silent  = (&since_report_q) ? since_report_q : since_report_q + 32'd1;
	assign edge_ok = tick.edge_seen && (!have_ref_q || 32'(elapsed) >= 32'(debounce_q));
	assign tmo_hit = silent >= timeout_q;
	assign mag_eff = (magnets_q == '0) ? MAG_W'(1) : magnets_q;

	// A report is loaded either by a timeout tick or at the end of a measurement.
	assign tmo_rep  = accept && !edge_ok && tmo_hit;
	assign rep_load = tmo_rep || (state_q == S_OUT);

	// One restoring step: bring down the next dividend bit and try the subtract.
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	assign freq_sat  = (|num_q[NW-1:FREQ_W]) ? '1 : num_q[FREQ_W-1:0];
	assign spd_round = 64'(t2_q) + 64'h80_0000;
	assign speed_sat = (|spd_round[63:56]) ? '1 : spd_round[55:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			magnets_q      <= MAG_W'(1);
			radius_q       <= RAD_W'(330);
			debounce_q     <= DEB_W'(5000);
			timeout_q      <= TMO_W'(10000000);
			since_edge_q   <= '0;
			since_report_q <= '0;
			have_ref_q     <= 1'b0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAGNETS:  magnets_q  <= cfg_data[MAG_W-1:0];
					REG_RADIUS:   radius_q   <= cfg_data[RAD_W-1:0];
					REG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
					REG_TIMEOUT:  timeout_q  <= cfg_data[TMO_W-1:0];
					default: ;
				endcase
			end

			if (rep_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (edge_ok) begin
							have_ref_q     <= 1'b1;
							since_edge_q   <= '0;
							since_report_q <= '0;
							if (have_ref_q) begin
								state_q <= S_DEN;
							end
						end else begin
							since_edge_q <= elapsed;
							if (tmo_hit) begin
								since_report_q <= '0;
								have_ref_q     <= 1'b0;
							end else begin
								since_report_q <= silent;
							end
						end
					end
				end
				S_DEN: state_q <= S_LOAD;
				S_LOAD: begin
					cnt_q   <= CW'(NW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_SPD1;
					end
				end
				S_SPD1: state_q <= S_SPD2;
				S_SPD2: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				period_q <= elapsed;
				if (tmo_rep) begin
					out_freq_q  <= '0;
					out_speed_q <= '0;
					out_tmo_q   <= 1'b1;
				end
			end
			S_DEN: den_q <= DW'(period_q) * DW'(mag_eff);
			S_LOAD: begin
				num_q <= NW'(FREQ_NUM_Q16) + NW'(den_q >> 1);
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
				num_q <= {num_q[NW-2:0], rem_ge};
			end
			S_SPD1: begin
				freq_q <= freq_sat;
				t1_q   <= T1W'(freq_sat) * T1W'(TWO_PI_Q16);
			end
			S_SPD2: t2_q <= T2W'(t1_q) * T2W'(radius_q);
			S_OUT: begin
				out_freq_q  <= freq_q;
				out_speed_q <= speed_sat;
				out_tmo_q   <= 1'b0;
			end
			default: ;
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.frequency_q16 = out_freq_q;
	assign result.speed_q8      = out_speed_q;
	assign result.timed_out     = out_tmo_q;

endmodule

// ----- rtl/hpt_checker.sv -----
// Port-level checks of the hall pulse tachometer, attached by the bind below.
// Depends on hpt_pkg for the field widths.
module hpt_checker import hpt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               tick_valid,
	input logic               tick_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [FREQ_W-1:0]  res_freq,
	input logic [SPEED_W-1:0] res_speed,
	input logic               res_tmo
);

	// A timeout report carries no measurement.
	a_tmo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_tmo) |-> (res_freq == '0 && res_speed == '0))
		else $error("timeout report with nonzero fields");

	// No tick is taken while a report is stuck at the output.
	a_no_accept_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |-> (!res_valid || res_ready))
		else $error("tick accepted while the output is stalled");

	// A report that arrives from a measurement appears only after a busy interval.
	a_meas_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid) && !res_tmo) |-> !$past(tick_ready))
		else $error("measurement report without a busy cycle");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("report dropped before it was taken");

endmodule

bind hall_pulse_tachometer hpt_checker u_hpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tick_valid(tick.valid),
	.tick_ready(tick.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_freq  (result.frequency_q16),
	.res_speed (result.speed_q8),
	.res_tmo   (result.timed_out)
);
